// ===== hdl/prmd_pkg.sv =====
// prmd_pkg: shared types and constants for the punctured reed-muller decoder
// holds the status codes and the controller/datapath command and status structs
// no dependencies

package prmd_pkg;

	localparam int WordW  = 31;
	localparam int DistW  = 5;
	localparam int CountW = 17;
	localparam int SelW   = 16;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_PARAM = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;
	localparam logic [1:0] ST_TOO_MANY  = 2'd3;

	localparam logic REG_QUBITS = 1'b0;
	localparam logic REG_ORDER  = 1'b1;

	typedef struct packed {
		logic       start;       // latch word, clear counters
		logic       sweep;       // build one generator row
		logic       set_status;
		logic [1:0] status_code;
		logic       enum_step;   // issue one candidate
		logic       load_out;    // move result into output register
	} prmd_cmd_t;

	typedef struct packed {
		logic params_bad;
		logic sweep_last;
		logic dim_over;
		logic word_long;
		logic enum_last;
		logic pipe_busy;
		logic out_free;
	} prmd_stat_t;

endpackage

// ===== hdl/prmd_ctrl.sv =====
// prmd_ctrl: sequencer for the decoder
// steps through row build, checks, gray enumeration and result hand-off
// depends on prmd_pkg

module prmd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  prmd_pkg::prmd_stat_t   stat,
	output prmd_pkg::prmd_cmd_t    cmd
);
	import prmd_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SWEEP  = 3'd1;
	localparam logic [2:0] S_CHECK  = 3'd2;
	localparam logic [2:0] S_ENUM   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					if (stat.params_bad) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_BAD_PARAM;
						state_d         = S_FINISH;
					end else begin
						state_d = S_SWEEP;
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.set_status = 1'b1;
				if (stat.dim_over) begin
					cmd.status_code = ST_TOO_MANY;
					state_d         = S_FINISH;
				end else if (stat.word_long) begin
					cmd.status_code = ST_TOO_LONG;
					state_d         = S_FINISH;
				end else begin
					cmd.status_code = ST_OK;
					state_d         = S_ENUM;
				end
			end
			S_ENUM: begin
				cmd.enum_step = 1'b1;
				if (stat.enum_last)
					state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!stat.pipe_busy)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ===== hdl/prmd_datapath.sv =====
// prmd_datapath: config registers, generator row store, gray enumeration pipeline
// and output register of the decoder
// depends on prmd_pkg

module prmd_datapath #(
	parameter int MAX_DIM     = 16,
	parameter int QUBIT_LIMIT = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic                   cfg_index,
	input  logic [3:0]             cfg_data,
	input  logic [30:0]            received_word,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [1:0]             status,
	output logic [30:0]            best_codeword,
	output logic [4:0]             best_distance,
	output logic [16:0]            tie_count,
	output logic [16:0]            candidate_count,
	output logic [15:0]            selection_mask,
	input  prmd_pkg::prmd_cmd_t    cmd,
	output prmd_pkg::prmd_stat_t   stat
);
	import prmd_pkg::*;

	localparam int SW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int TW = ((QUBIT_LIMIT + 1) > (SW + 1)) ? (QUBIT_LIMIT + 1) : (SW + 1);
	localparam int IW = MAX_DIM + 1;
	localparam int MW = QUBIT_LIMIT;

	logic [2:0]         qubits_q;
	logic [3:0]         order_q;
	logic [WordW-1:0]   word_q;
	logic [1:0]         status_q;

	logic [MW-1:0]      mask_q;
	logic [TW-1:0]      dim_q;
	logic [WordW-1:0]   store_q [MAX_DIM];

	logic [IW-1:0]      idx_q;
	logic [WordW-1:0]   running_s1;
	logic [IW-1:0]      gray_s1;
	logic               v_s1, first_s1;
	logic [WordW-1:0]   cw_s2;
	logic [IW-1:0]      gray_s2;
	logic [DistW-1:0]   dist_s2;
	logic               v_s2, first_s2;

	logic [WordW-1:0]   best_cw_q;
	logic [DistW-1:0]   best_dist_q;
	logic [IW-1:0]      best_sel_q;
	logic [IW-1:0]      ties_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [WordW-1:0]   out_cw_q;
	logic [DistW-1:0]   out_dist_q;
	logic [CountW-1:0]  out_ties_q;
	logic [CountW-1:0]  out_cand_q;
	logic [SelW-1:0]    out_sel_q;

	logic [5:0]         n_pts;
	logic [WordW-1:0]   valid_bits;
	logic [WordW-1:0]   row;
	logic               term_ok;
	logic [IW-1:0]      cand;
	logic [SW-1:0]      flip_k;
	logic [IW-1:0]      gray;

	// point count n = 2^q - 1 and the bits that lie on the code
	always_comb begin
		n_pts      = (6'd1 << qubits_q) - 6'd1;
		valid_bits = 31'h7FFF_FFFF >> (6'd31 - n_pts);
	end

	// evaluation of the current monomial at points 1..n
	always_comb begin
		row = '0;
		for (int p = 1; p <= WordW; p++) begin
			row[p-1] = (mask_q == '0) || ((5'(mask_q) & 5'(p)) == 5'(mask_q));
		end
		row     = row & valid_bits;
		term_ok = !order_q[3] && (4'($countones(mask_q)) <= order_q);
	end

	// the bit that flips at gray step idx is the lowest set bit of idx
	always_comb begin
		flip_k = '0;
		for (int i = MAX_DIM - 1; i >= 0; i--) begin
			if (idx_q[i])
				flip_k = SW'(i);
		end
		gray = idx_q ^ (idx_q >> 1);
		cand = IW'(1) << dim_q;
	end

	always_comb begin
		stat.params_bad = (qubits_q == 3'd0) || (qubits_q > 3'(QUBIT_LIMIT)) ||
			($signed(order_q) < -4'sd1) || ($signed(order_q) >= $signed({1'b0, qubits_q}));
		stat.sweep_last = (mask_q == MW'(n_pts));
		stat.dim_over   = (dim_q > TW'(MAX_DIM));
		stat.word_long  = ((word_q & ~valid_bits) != '0);
		stat.enum_last  = (idx_q == cand - IW'(1));
		stat.pipe_busy  = v_s1 || v_s2;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubits_q <= 3'd5;
			order_q  <= 4'd2;
		end else if (cfg_write) begin
			if (cfg_index == REG_QUBITS)
				qubits_q <= cfg_data[2:0];
			else
				order_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.enum_step;
			v_s2 <= v_s1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep && term_ok && (dim_q < TW'(MAX_DIM)))
			store_q[dim_q[SW-1:0]] <= row;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			word_q <= received_word;
			mask_q <= '0;
			dim_q  <= '0;
			idx_q  <= '0;
		end
		if (cmd.sweep) begin
			mask_q <= mask_q + MW'(1);
			if (term_ok)
				dim_q <= dim_q + TW'(1);
		end
		if (cmd.set_status)
			status_q <= cmd.status_code;

		// stage 1: running codeword steps through gray order
		if (cmd.enum_step) begin
			idx_q    <= idx_q + IW'(1);
			gray_s1  <= gray;
			first_s1 <= (idx_q == '0);
			if (idx_q == '0)
				running_s1 <= '0;
			else
				running_s1 <= running_s1 ^ store_q[flip_k];
		end

		// stage 2: distance to the received word
		cw_s2    <= running_s1;
		gray_s2  <= gray_s1;
		first_s2 <= first_s1;
		dist_s2  <= DistW'($countones(word_q ^ running_s1));

		// stage 3: keep the best candidate, ties go to the smaller value
		if (v_s2) begin
			if (first_s2 || (dist_s2 < best_dist_q)) begin
				best_cw_q   <= cw_s2;
				best_dist_q <= dist_s2;
				best_sel_q  <= gray_s2;
				ties_q      <= IW'(1);
			end else if (dist_s2 == best_dist_q) begin
				ties_q <= ties_q + IW'(1);
				if (cw_s2 < best_cw_q) begin
					best_cw_q  <= cw_s2;
					best_sel_q <= gray_s2;
				end
			end
		end

		if (cmd.load_out) begin
			out_status_q <= status_q;
			if (status_q == ST_OK) begin
				out_cw_q   <= best_cw_q;
				out_dist_q <= best_dist_q;
				out_ties_q <= CountW'(ties_q);
				out_cand_q <= CountW'(cand);
				out_sel_q  <= SelW'(best_sel_q);
			end else begin
				out_cw_q   <= '0;
				out_dist_q <= '0;
				out_ties_q <= '0;
				out_cand_q <= '0;
				out_sel_q  <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign best_codeword   = out_cw_q;
	assign best_distance   = out_dist_q;
	assign tie_count       = out_ties_q;
	assign candidate_count = out_cand_q;
	assign selection_mask  = out_sel_q;

endmodule

// ===== hdl/punctured_reed_muller_exact_decoder.sv =====
// punctured_reed_muller_exact_decoder: exact nearest-codeword decoder for the
// punctured reed-muller code, top level joining controller and datapath
// depends on prmd_pkg, prmd_ctrl, prmd_datapath
//
// usage:
//   received_word enters on in_valid/in_ready; one word is decoded at a time.
//   the result word leaves on out_valid/out_ready with status, best_codeword,
//   best_distance, tie_count, candidate_count and selection_mask.
//   qubit_count (index 0) and code_order (index 1) are written through
//   cfg_write/cfg_index/cfg_data while the decoder is idle.
// from the accepted word to out_valid, for a word with good parameters:
//   the generator rows are built over all 2^q monomial masks, the checks run,
//   then all 2^dim codewords are walked in gray order (one candidate per cycle
//   through a three-stage xor/popcount/compare pipe), the pipe drains, the result loads.
//   at the default q=5, order 2 the code has dim 16.
//   a word with bad parameters goes straight to the result hand-off; a rejected
//   word goes to it after the row build and the checks.
// reset clears the config registers to q=5, order 2, and empties the output.
// a stalled receiver holds the result in the output register; the decoder
//   still takes the next word and only waits at the point of handing over
//   its own result.

module punctured_reed_muller_exact_decoder #(
	parameter int MAX_DIM     = 16,
	parameter int QUBIT_LIMIT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] received_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [30:0] best_codeword,
	output logic [4:0]  best_distance,
	output logic [16:0] tie_count,
	output logic [16:0] candidate_count,
	output logic [15:0] selection_mask
);
	import prmd_pkg::*;

	prmd_cmd_t  cmd;
	prmd_stat_t stat;

	prmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	prmd_datapath #(
		.MAX_DIM     (MAX_DIM),
		.QUBIT_LIMIT (QUBIT_LIMIT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.received_word   (received_word),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.best_codeword   (best_codeword),
		.best_distance   (best_distance),
		.tie_count       (tie_count),
		.candidate_count (candidate_count),
		.selection_mask  (selection_mask),
		.cmd             (cmd),
		.stat            (stat)
	);

endmodule
